### hw/rtl/apd_pkg.sv
// Package for the averaged peak press detector.
// Holds field widths, register indexes, the configuration struct and the
// sequencer state type. No dependencies.
`default_nettype none

package apd_pkg;

	localparam int SAMPLE_W = 10;
	localparam int COUNT_W  = 8;
	localparam int TICKS_W  = 16;
	localparam int TIME_W   = 32;
	localparam int SUM_W    = 18;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	// The divider retires one quotient bit per step.
	localparam int DIV_STEPS = SUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		REG_SAMPLE_COUNT    = 2'd0,
		REG_THRESHOLD       = 2'd1,
		REG_COOLDOWN_TICKS  = 2'd2,
		REG_MIN_PRESS_TICKS = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  sample_count;
		logic [SAMPLE_W-1:0] threshold;
		logic [TICKS_W-1:0]  cooldown_ticks;
		logic [TICKS_W-1:0]  min_press_ticks;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

### hw/rtl/apd_regs.sv
// Configuration register file with an APB-style access port.
// Depends on apd_pkg for register indexes and the cfg_t struct.
`default_nettype none

module apd_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [apd_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [apd_pkg::DATA_W-1:0]  pwdata,
	output logic      [apd_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	output apd_pkg::cfg_t                    cfg
);
	import apd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_count    <= COUNT_W'(1);
			cfg_q.threshold       <= '0;
			cfg_q.cooldown_ticks  <= '0;
			cfg_q.min_press_ticks <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_SAMPLE_COUNT:    cfg_q.sample_count    <= pwdata[COUNT_W-1:0];
				REG_THRESHOLD:       cfg_q.threshold       <= pwdata[SAMPLE_W-1:0];
				REG_COOLDOWN_TICKS:  cfg_q.cooldown_ticks  <= pwdata[TICKS_W-1:0];
				REG_MIN_PRESS_TICKS: cfg_q.min_press_ticks <= pwdata[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SAMPLE_COUNT:    prdata = DATA_W'(cfg_q.sample_count);
			REG_THRESHOLD:       prdata = DATA_W'(cfg_q.threshold);
			REG_COOLDOWN_TICKS:  prdata = DATA_W'(cfg_q.cooldown_ticks);
			REG_MIN_PRESS_TICKS: prdata = DATA_W'(cfg_q.min_press_ticks);
			default:             prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/apd_div.sv
// Bit-serial restoring divider: block sum over sample count, one quotient
// bit per cycle. Depends on apd_pkg for widths.
`default_nettype none

module apd_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [apd_pkg::SUM_W-1:0]   dividend,
	input  wire logic [apd_pkg::COUNT_W-1:0] divisor,
	output logic                             done,
	output logic      [apd_pkg::SUM_W-1:0]   quotient
);
	import apd_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]     quo_q;
	logic [COUNT_W-1:0]   rem_q;
	logic [COUNT_W-1:0]   dvs_q;

	logic [COUNT_W:0]     rem_shift;
	logic [COUNT_W+1:0]   diff;
	logic                 fits;

	// The dividend shifts out of the top of quo_q while quotient bits
	// shift in at the bottom.
	assign rem_shift = {rem_q, quo_q[SUM_W-1]};
	assign diff      = {1'b0, rem_shift} - {2'b0, dvs_q};
	assign fits      = !diff[COUNT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### hw/rtl/averaged_peak_press_detector_core.sv
// Averaged peak press detector. A sample inside a block is taken while the sequencer idles; a
// sample that ends a block stalls the input through the divide state (start, 18-step serial
// divider, hand-off) and, if it closes a window, the emit state, which loads its result
// beat into the output register. Throughput: one sample per cycle mid block; a block end
// holds off new samples until the sequencer is idle, also while the result side stalls.
// Reset clears the sequencer, time counters and window; registers go to count 1, else 0.
`default_nettype none

module averaged_peak_press_detector_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [apd_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [apd_pkg::DATA_W-1:0]   pwdata,
	output logic      [apd_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	input  wire logic                         sample_valid,
	output logic                              sample_stall,
	input  wire logic [apd_pkg::SAMPLE_W-1:0] sample,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic      [apd_pkg::SAMPLE_W-1:0] reading,
	output logic                              accepted
);
	import apd_pkg::*;

	cfg_t cfg;

	state_t state_q, state_d;

	logic [TIME_W-1:0]   tick_q;
	logic [TIME_W-1:0]   last_q;
	logic [TIME_W-1:0]   start_q;
	logic [SUM_W-1:0]    sum_q;
	logic [COUNT_W-1:0]  idx_q;
	logic                open_q;
	logic [SAMPLE_W-1:0] peak_q;
	logic [SAMPLE_W-1:0] res_reading_q;
	logic                res_ok_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_reading_q;
	logic                out_ok_q;

	logic                take;
	logic                cooling;
	logic [SUM_W-1:0]    base_sum;
	logic [COUNT_W-1:0]  base_idx;
	logic [SUM_W-1:0]    new_sum;
	logic [COUNT_W-1:0]  new_idx;
	logic [COUNT_W-1:0]  count;
	logic                block_end;
	logic                div_start;
	logic                div_done;
	logic [SUM_W-1:0]    quotient;
	logic [SAMPLE_W-1:0] avg;
	logic [SAMPLE_W-1:0] new_peak;
	logic                closing;
	logic                press_ok;
	logic                out_free;
	logic                load_out;

	apd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	apd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (new_sum),
		.divisor  (count),
		.done     (div_done),
		.quotient (quotient)
	);

	assign take    = sample_valid && !sample_stall;
	// The time counters count taken samples modulo 2^32, so the differences wrap.
	assign cooling = !open_q &&
		((tick_q - last_q) < {{(TIME_W-TICKS_W){1'b0}}, cfg.cooldown_ticks});

	assign base_sum  = open_q ? sum_q : '0;
	assign base_idx  = open_q ? idx_q : '0;
	assign new_sum   = base_sum + SUM_W'(sample);
	assign new_idx   = base_idx + COUNT_W'(1);
	assign count     = (cfg.sample_count == '0) ? COUNT_W'(1) : cfg.sample_count;
	assign block_end = new_idx >= count;
	assign div_start = take && !cooling && block_end;

	// The average keeps only its low bits when the count was lowered mid block.
	assign avg      = quotient[SAMPLE_W-1:0];
	assign new_peak = (avg > peak_q) ? avg : peak_q;
	assign closing  = avg <= cfg.threshold;
	// tick_q already holds the close time: the tick after the last sample.
	assign press_ok = (tick_q - start_q) >= {{(TIME_W-TICKS_W){1'b0}}, cfg.min_press_ticks};

	assign out_free = !out_valid_q || !result_stall;

	always_comb begin
		state_d      = state_q;
		sample_stall = 1'b1;
		load_out     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				if (div_start) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = closing ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			last_q  <= '0;
			start_q <= '0;
			sum_q   <= '0;
			idx_q   <= '0;
			open_q  <= 1'b0;
			peak_q  <= '0;
		end else begin
			if (take) begin
				tick_q <= tick_q + TIME_W'(1);
				if (!cooling) begin
					if (!open_q) begin
						open_q  <= 1'b1;
						start_q <= tick_q;
						peak_q  <= '0;
					end
					if (block_end) begin
						sum_q <= '0;
						idx_q <= '0;
					end else begin
						sum_q <= new_sum;
						idx_q <= new_idx;
					end
				end
			end
			if (state_q == ST_DIV && div_done) begin
				peak_q <= new_peak;
				if (closing) begin
					open_q <= 1'b0;
					if (press_ok) begin
						last_q <= tick_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && div_done) begin
			res_reading_q <= press_ok ? new_peak : '0;
			res_ok_q      <= press_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_reading_q <= res_reading_q;
			out_ok_q      <= res_ok_q;
		end
	end

	assign result_valid = out_valid_q;
	assign reading      = out_reading_q;
	assign accepted     = out_ok_q;

	a_closed_window_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> (idx_q == '0 && sum_q == '0))
		else $error("closed window left a partial block behind");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_EMIT))
		else $error("result beat raised without a closing window");

	a_rejected_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !accepted) |-> reading == '0)
		else $error("rejected window carries a nonzero reading");

	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |=> (state_q == ST_DIV || state_q == ST_EMIT ||
			!$past(open_q) || state_q == ST_IDLE) && !$past(take))
		else $error("sample taken while a block average was pending");

endmodule

`default_nettype wire
